/* rtl/lr_pkg.sv */
package lr_pkg;

	// Operation codes carried on the command channel.
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Two-bit step direction codes.
	localparam logic [1:0] DIR_ZERO = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd3;

	// Default framebuffer line stride in pixels.
	localparam int DEF_LINE_STRIDE = 240;

	// Step directions for both kinds of step.
	typedef struct packed {
		logic [1:0] straight_y;
		logic [1:0] straight_x;
		logic [1:0] diag_y;
		logic [1:0] diag_x;
	} step_dirs_t;

	// Walk parameters derived from a start word.
	typedef struct packed {
		logic [7:0] major_len;
		logic [7:0] minor_len;
		step_dirs_t dirs;
		logic [8:0] error_init;
		logic [8:0] pixels;
	} line_setup_t;

	// One pixel leaving the walker, before address generation.
	typedef struct packed {
		logic [7:0]  x;
		logic [7:0]  y;
		logic [15:0] color;
		logic        last;
	} pixel_t;

	// Wrapping 8-bit addend for a direction code.
	function automatic logic [7:0] dir_add(input logic [1:0] code);
		logic [7:0] res;
		begin
			unique case (code)
				DIR_POS: res = 8'h01;
				DIR_NEG: res = 8'hFF;
				default: res = 8'h00;
			endcase
			return res;
		end
	endfunction

endpackage

/* rtl/lr_setup.sv */
module lr_setup (
	input  logic [7:0]          start_x,
	input  logic [7:0]          start_y,
	input  logic [7:0]          end_x,
	input  logic [7:0]          end_y,
	output lr_pkg::line_setup_t setup
);
	import lr_pkg::*;

	logic [8:0] dx;
	logic [8:0] dy;
	logic [7:0] abs_dx;
	logic [7:0] abs_dy;
	logic [1:0] dir_x;
	logic [1:0] dir_y;
	logic       x_major;

	// Signed differences and their magnitudes.
	assign dx = {1'b0, end_x} - {1'b0, start_x};
	assign dy = {1'b0, end_y} - {1'b0, start_y};
	assign abs_dx = dx[8] ? 8'(-dx) : dx[7:0];
	assign abs_dy = dy[8] ? 8'(-dy) : dy[7:0];

	// Sign of each difference as a direction code.
	assign dir_x = dx[8] ? DIR_NEG : ((dx == 9'd0) ? DIR_ZERO : DIR_POS);
	assign dir_y = dy[8] ? DIR_NEG : ((dy == 9'd0) ? DIR_ZERO : DIR_POS);

	// On a tie the y axis is the major one.
	assign x_major = abs_dx > abs_dy;

	// Axis lengths, step directions and initial error.
	always_comb begin
		setup.major_len       = x_major ? abs_dx : abs_dy;
		setup.minor_len       = x_major ? abs_dy : abs_dx;
		setup.dirs.diag_x     = dir_x;
		setup.dirs.diag_y     = dir_y;
		setup.dirs.straight_x = x_major ? dir_x : DIR_ZERO;
		setup.dirs.straight_y = x_major ? DIR_ZERO : dir_y;
		setup.error_init      = {2'b00, setup.major_len[7:1]};
		setup.pixels          = {1'b0, setup.major_len} + 9'd1;
	end

endmodule

/* rtl/lr_walk.sv */
module lr_walk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                op,
	input  logic [7:0]          start_x,
	input  logic [7:0]          start_y,
	input  logic [15:0]         line_color,
	input  lr_pkg::line_setup_t setup,
	output logic                emit,
	output lr_pkg::pixel_t      pixel
);
	import lr_pkg::*;

	logic       busy_q;
	logic [7:0] cur_x_q;
	logic [7:0] cur_y_q;
	logic [8:0] error_acc_q;
	logic [7:0] major_len_q;
	logic [7:0] minor_len_q;
	logic [8:0] pixels_left_q;
	step_dirs_t dirs_q;
	logic [15:0] color_q;

	logic [8:0] acc_sum;
	logic       diag_step;
	logic [8:0] acc_next;
	logic [7:0] x_next;
	logic [7:0] y_next;

	// A tick while a line is active produces one pixel word.
	assign emit = accept && (op == OP_TICK) && busy_q;

	// Current pixel as it leaves on this tick.
	always_comb begin
		pixel.x     = cur_x_q;
		pixel.y     = cur_y_q;
		pixel.color = color_q;
		pixel.last  = pixels_left_q == 9'd1;
	end

	// Error update and choice between diagonal and straight step.
	assign acc_sum   = error_acc_q + {1'b0, minor_len_q};
	assign diag_step = acc_sum >= {1'b0, major_len_q};
	assign acc_next  = diag_step ? (acc_sum - {1'b0, major_len_q}) : acc_sum;
	assign x_next    = cur_x_q + dir_add(diag_step ? dirs_q.diag_x : dirs_q.straight_x);
	assign y_next    = cur_y_q + dir_add(diag_step ? dirs_q.diag_y : dirs_q.straight_y);

	// Walk state: loaded by a start word, advanced by each emitting tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			error_acc_q   <= '0;
			major_len_q   <= '0;
			minor_len_q   <= '0;
			pixels_left_q <= '0;
			dirs_q        <= '0;
			color_q       <= '0;
		end else if (accept && (op == OP_START)) begin
			busy_q        <= 1'b1;
			cur_x_q       <= start_x;
			cur_y_q       <= start_y;
			error_acc_q   <= setup.error_init;
			major_len_q   <= setup.major_len;
			minor_len_q   <= setup.minor_len;
			pixels_left_q <= setup.pixels;
			dirs_q        <= setup.dirs;
			color_q       <= line_color;
		end else if (emit) begin
			cur_x_q     <= x_next;
			cur_y_q     <= y_next;
			error_acc_q <= acc_next;
			if (pixels_left_q <= 9'd1) begin
				pixels_left_q <= '0;
				busy_q        <= 1'b0;
			end else begin
				pixels_left_q <= pixels_left_q - 9'd1;
			end
		end
	end

endmodule

/* rtl/lr_out_reg.sv */
module lr_out_reg #(
	parameter int LINE_STRIDE = lr_pkg::DEF_LINE_STRIDE
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           emit,
	input  lr_pkg::pixel_t pixel,
	input  logic           pix_stall,
	output logic           pix_valid,
	output logic [7:0]     pixel_x,
	output logic [7:0]     pixel_y,
	output logic [15:0]    pixel_address,
	output logic [15:0]    pixel_color,
	output logic           last
);
	import lr_pkg::*;

	localparam logic [8:0] STRIDE = 9'(LINE_STRIDE);

	logic        valid_q;
	logic [16:0] row_base;
	logic [15:0] address;

	// Framebuffer address: row times stride plus column, kept to 16 bits.
	assign row_base = 17'(pixel.y) * 17'(STRIDE);
	assign address  = 16'(row_base + 17'(pixel.x));

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit) begin
			valid_q <= 1'b1;
		end else if (!pix_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload, loaded only when a new word arrives.
	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x       <= pixel.x;
			pixel_y       <= pixel.y;
			pixel_address <= address;
			pixel_color   <= pixel.color;
			last          <= pixel.last;
		end
	end

	assign pix_valid = valid_q;

endmodule

/* rtl/line_rasterizer.sv */
// A tick word that produces a pixel shows it on pix_valid in the cycle after acceptance.
// Throughput: one command word per cycle while cmd_stall is low; a start word gives no pixel.
// The rate is set by the combinational error update loop in the walker.
// cmd_stall is high only while an output word waits and pix_stall is high.
// Reset (arst_n low, asynchronous) leaves the block idle with no pending output word.
module line_rasterizer #(
	parameter int LINE_STRIDE = lr_pkg::DEF_LINE_STRIDE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        op,
	input  logic [7:0]  start_x,
	input  logic [7:0]  start_y,
	input  logic [7:0]  end_x,
	input  logic [7:0]  end_y,
	input  logic [15:0] line_color,
	output logic        pix_valid,
	input  logic        pix_stall,
	output logic [7:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [15:0] pixel_address,
	output logic [15:0] pixel_color,
	output logic        last
);
	import lr_pkg::*;

	line_setup_t setup;
	pixel_t      pixel;
	logic        accept;
	logic        emit;

	// Hold commands while the output word cannot move.
	assign cmd_stall = pix_valid && pix_stall;
	assign accept    = cmd_valid && !cmd_stall;

	// Start word decode.
	lr_setup u_setup (
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.setup   (setup)
	);

	// Line walk state.
	lr_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.op         (op),
		.start_x    (start_x),
		.start_y    (start_y),
		.line_color (line_color),
		.setup      (setup),
		.emit       (emit),
		.pixel      (pixel)
	);

	// Address generation and output register.
	lr_out_reg #(
		.LINE_STRIDE (LINE_STRIDE)
	) u_out_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.emit          (emit),
		.pixel         (pixel),
		.pix_stall     (pix_stall),
		.pix_valid     (pix_valid),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last          (last)
	);

endmodule

/* dv/tb.sv */
// One expected pixel word, laid out in port order.
typedef struct packed {
	logic [7:0]  x;
	logic [7:0]  y;
	logic [15:0] address;
	logic [15:0] color;
	logic        last;
} pixel_word_t;

// Predicts the pixel stream of the line walker and checks the block against it.
class pixel_scoreboard;
	// Private copy of the walker state.
	bit                busy;
	logic [7:0]        cur_x;
	logic [7:0]        cur_y;
	logic [8:0]        err_acc;
	logic [7:0]        major_len;
	logic [7:0]        minor_len;
	logic [8:0]        pixels_left;
	lr_pkg::step_dirs_t dirs;
	logic [15:0]       color;

	pixel_word_t expected_q[$];
	int errors;
	int words_seen;
	int lines_started;
	int pixels_checked;

	function new();
		busy = 1'b0;
		cur_x = '0;
		cur_y = '0;
		err_acc = '0;
		major_len = '0;
		minor_len = '0;
		pixels_left = '0;
		dirs = '0;
		color = '0;
		errors = 0;
		words_seen = 0;
		lines_started = 0;
		pixels_checked = 0;
	endfunction

	// Direction code for the sign of a coordinate difference.
	function logic [1:0] sign_code(int d);
		if (d > 0)
			return lr_pkg::DIR_POS;
		if (d < 0)
			return lr_pkg::DIR_NEG;
		return lr_pkg::DIR_ZERO;
	endfunction

	// Wrapping 8-bit move for one direction code.
	function logic [7:0] step_amount(logic [1:0] code);
		case (code)
			lr_pkg::DIR_POS: return 8'h01;
			lr_pkg::DIR_NEG: return 8'hFF;
			default: return 8'h00;
		endcase
	endfunction

	// One line of output per mismatch, and a running count.
	task report_mismatch(string what);
		errors++;
		$display("ERROR @%0t: %s", $time, what);
	endtask

	// Takes an accepted command word and queues the pixel it produces, if any.
	function void note_word(logic o, logic [7:0] sx, logic [7:0] sy, logic [7:0] ex,
			logic [7:0] ey, logic [15:0] c);
		int dx;
		int dy;
		int adx;
		int ady;
		logic [8:0] acc;
		pixel_word_t px;
		words_seen++;
		if (o == lr_pkg::OP_START) begin
			dx = int'(ex) - int'(sx);
			dy = int'(ey) - int'(sy);
			adx = (dx < 0) ? -dx : dx;
			ady = (dy < 0) ? -dy : dy;
			dirs.diag_x = sign_code(dx);
			dirs.diag_y = sign_code(dy);
			// A tie of the two axes goes to y, so every step is diagonal.
			if (adx > ady) begin
				major_len = 8'(adx);
				minor_len = 8'(ady);
				dirs.straight_x = dirs.diag_x;
				dirs.straight_y = lr_pkg::DIR_ZERO;
			end else begin
				major_len = 8'(ady);
				minor_len = 8'(adx);
				dirs.straight_x = lr_pkg::DIR_ZERO;
				dirs.straight_y = dirs.diag_y;
			end
			err_acc = 9'(major_len >> 1);
			pixels_left = 9'(major_len) + 9'd1;
			cur_x = sx;
			cur_y = sy;
			color = c;
			busy = 1'b1;
			lines_started++;
		end else if (busy) begin
			px.x = cur_x;
			px.y = cur_y;
			px.address = 16'(int'(cur_y) * lr_pkg::DEF_LINE_STRIDE + int'(cur_x));
			px.color = color;
			px.last = (pixels_left == 9'd1);
			expected_q.push_back(px);
			// Error update picks a diagonal or a straight step.
			acc = err_acc + 9'(minor_len);
			if (acc >= 9'(major_len)) begin
				acc = acc - 9'(major_len);
				cur_x = cur_x + step_amount(dirs.diag_x);
				cur_y = cur_y + step_amount(dirs.diag_y);
			end else begin
				cur_x = cur_x + step_amount(dirs.straight_x);
				cur_y = cur_y + step_amount(dirs.straight_y);
			end
			err_acc = acc;
			if (pixels_left <= 9'd1) begin
				pixels_left = '0;
				busy = 1'b0;
			end else begin
				pixels_left = pixels_left - 9'd1;
			end
		end
	endfunction

	// Compares an accepted pixel word with the oldest expected one.
	task check_pixel(pixel_word_t got);
		pixel_word_t want;
		if (expected_q.size() == 0) begin
			report_mismatch($sformatf("pixel word (%0d,%0d) with none expected", got.x, got.y));
			return;
		end
		want = expected_q.pop_front();
		pixels_checked++;
		if (got.x !== want.x)
			report_mismatch($sformatf("pixel_x %0d, expected %0d", got.x, want.x));
		if (got.y !== want.y)
			report_mismatch($sformatf("pixel_y %0d, expected %0d", got.y, want.y));
		if (got.address !== want.address)
			report_mismatch($sformatf("pixel_address %0d, expected %0d",
				got.address, want.address));
		if (got.color !== want.color)
			report_mismatch($sformatf("pixel_color %h, expected %h", got.color, want.color));
		if (got.last !== want.last)
			report_mismatch($sformatf("last %b, expected %b at (%0d,%0d)",
				got.last, want.last, want.x, want.y));
	endtask
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lr_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_WORDS = 480;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic        op = OP_TICK;
	logic [7:0]  start_x = '0;
	logic [7:0]  start_y = '0;
	logic [7:0]  end_x = '0;
	logic [7:0]  end_y = '0;
	logic [15:0] line_color = '0;
	logic        pix_valid;
	logic        pix_stall = 1'b0;
	logic [7:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [15:0] pixel_address;
	logic [15:0] pixel_color;
	logic        last;

	pixel_scoreboard sb;
	bit cmd_taken = 1'b0;
	int words_sent = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int cycles = 0;

	line_rasterizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.op(op),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.line_color(line_color),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_address(pixel_address),
		.pixel_color(pixel_color),
		.last(last)
	);

	// Clock: 4 ns high, 4 ns low.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run time guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d pixel words outstanding.",
				cycles, sb.expected_q.size());
			$display("line_rasterizer: mismatch");
			$finish;
		end
	end

	// Both handshakes are sampled at the rising edge; pixels are checked before
	// the command word of the same edge is predicted.
	always @(posedge clk) begin
		cmd_taken = 1'b0;
		if (arst_n) begin
			if (pix_valid && !pix_stall)
				sb.check_pixel({pixel_x, pixel_y, pixel_address, pixel_color, last});
			cmd_taken = cmd_valid && !cmd_stall;
			if (cmd_taken)
				sb.note_word(op, start_x, start_y, end_x, end_y, line_color);
		end
	end

	// Receiver back-pressure, changed at the falling edge.
	always @(negedge clk) begin
		pix_stall = arst_n && ($urandom_range(99) < stall_pct);
	end

	// Presents one command word after a random idle gap and holds it until taken.
	task automatic send_word(input logic o, input logic [7:0] sx, input logic [7:0] sy,
			input logic [7:0] ex, input logic [7:0] ey, input logic [15:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid = 1'b0;
			op = 1'($urandom);
			start_x = 8'($urandom);
			end_y = 8'($urandom);
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		op = o;
		start_x = sx;
		start_y = sy;
		end_x = ex;
		end_y = ey;
		line_color = c;
		@(negedge clk);
		while (!cmd_taken)
			@(negedge clk);
		words_sent++;
	endtask

	// A tick word; its coordinate fields carry noise that the block ignores.
	task automatic send_tick();
		send_word(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			16'($urandom));
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_tick();
	endtask

	// Moves a coordinate by a small random amount, clamped to the screen.
	function automatic logic [7:0] nudge(input logic [7:0] c);
		int v;
		v = int'(c) + int'($urandom_range(24)) - 12;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	// Random lines: mostly complete walks, some with idle ticks after them and
	// some cut short by the next start word.
	task automatic run_lines(input int count);
		int stop_at;
		int pick;
		int d;
		int npix;
		logic [7:0] sx;
		logic [7:0] sy;
		logic [7:0] ex;
		logic [7:0] ey;
		stop_at = words_sent + count;
		while (words_sent < stop_at) begin
			sx = 8'($urandom);
			sy = 8'($urandom);
			pick = $urandom_range(99);
			if (pick < 60) begin
				ex = nudge(sx);
				ey = nudge(sy);
			end else if (pick < 88) begin
				ex = 8'($urandom);
				ey = 8'($urandom);
			end else begin
				// Straight, diagonal and single-point lines.
				d = $urandom_range(1, 40);
				ex = sx;
				ey = sy;
				case ($urandom_range(3))
					0: ex = 8'($urandom);
					1: ey = 8'($urandom);
					2: begin
						ex = (sx < 8'd128) ? sx + 8'(d) : sx - 8'(d);
						ey = (sy < 8'd128) ? sy + 8'(d) : sy - 8'(d);
					end
					default: ;
				endcase
			end
			d = (int'(ex) > int'(sx)) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
			npix = (int'(ey) > int'(sy)) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
			npix = ((d > npix) ? d : npix) + 1;
			send_word(OP_START, sx, sy, ex, ey, 16'($urandom));
			pick = $urandom_range(99);
			if (pick < 75)
				send_ticks(npix);
			else if (pick < 88)
				send_ticks(npix + $urandom_range(1, 3));
			else
				send_ticks($urandom_range(0, npix - 1));
		end
	endtask

	initial begin
		sb = new();
		repeat (6)
			@(negedge clk);
		arst_n = 1'b1;

		// Directed words, no idling: tick while idle, the four corners with both
		// color extremes, a tied diagonal, restarts in the middle of a line, a
		// single point and a short complete line followed by an idle tick.
		send_tick();
		send_word(OP_START, 8'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF);
		send_ticks(3);
		send_word(OP_START, 8'd255, 8'd255, 8'd0, 8'd0, 16'h0000);
		send_ticks(2);
		send_word(OP_START, 8'd255, 8'd0, 8'd0, 8'd3, 16'hAAAA);
		send_ticks(3);
		send_word(OP_START, 8'd0, 8'd255, 8'd2, 8'd0, 16'h5555);
		send_ticks(3);
		send_word(OP_START, 8'd9, 8'd9, 8'd9, 8'd9, 16'h1234);
		send_ticks(2);
		send_word(OP_START, 8'd10, 8'd20, 8'd13, 8'd20, 16'h8001);
		send_ticks(5);

		// Random lines under four mixes of sender gaps and receiver stalls.
		send_idle_pct = 0;
		stall_pct = 0;
		run_lines(PHASE_WORDS);
		send_idle_pct = 77;
		stall_pct = 0;
		run_lines(PHASE_WORDS);
		send_idle_pct = 0;
		stall_pct = 77;
		run_lines(PHASE_WORDS);
		send_idle_pct = 20;
		stall_pct = 20;
		run_lines(PHASE_WORDS);

		// Drain the remaining pixels, then allow for the output latency.
		cmd_valid = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (8)
			@(negedge clk);

		$display("Sent %0d command words: %0d lines started, %0d pixel words checked.",
			sb.words_seen, sb.lines_started, sb.pixels_checked);
		$display("Mismatches: %0d.", sb.errors);
		if (sb.errors == 0)
			$display("line_rasterizer: match");
		else
			$display("line_rasterizer: mismatch");
		$finish;
	end
endmodule
